@@ rtl/chft_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, framing constants and helper functions for the CRC-16 hex framer.
// No dependencies.
package chft_pkg;

  // One framing job: a payload byte plus what goes around it
  typedef struct packed {
    logic [7:0]  data;     // payload byte
    logic [15:0] crc;      // CRC after this byte
    logic        prefix;   // send 05 05 03 03 first
    logic        tail;     // send hex CRC and CR LF after
  } job_t;

  // Output sequence positions
  localparam logic [3:0] STEP_PRE0 = 4'd0;
  localparam logic [3:0] STEP_PRE1 = 4'd1;
  localparam logic [3:0] STEP_PRE2 = 4'd2;
  localparam logic [3:0] STEP_PRE3 = 4'd3;
  localparam logic [3:0] STEP_DATA = 4'd4;
  localparam logic [3:0] STEP_HEX3 = 4'd5;
  localparam logic [3:0] STEP_HEX2 = 4'd6;
  localparam logic [3:0] STEP_HEX1 = 4'd7;
  localparam logic [3:0] STEP_HEX0 = 4'd8;
  localparam logic [3:0] STEP_CR   = 4'd9;
  localparam logic [3:0] STEP_LF   = 4'd10;

  localparam logic [7:0] PREFIX_A = 8'h05;
  localparam logic [7:0] PREFIX_B = 8'h03;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_0   = 8'h30;
  localparam logic [7:0] CHAR_A   = 8'h41;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Bytewise CRC-16, MSB first, no reflection
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Upper-case ASCII hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = CHAR_0 + {4'd0, n};
    end else begin
      r = CHAR_A + {4'd0, n} - 8'd10;
    end
    return r;
  endfunction

endpackage

@@ rtl/chft_seq.sv @@
`timescale 1ns / 1ps
// Two-entry job queue and output byte sequencer for the CRC-16 hex framer.
// Depends on chft_pkg.
module chft_seq (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  chft_pkg::job_t job,
  output logic          stream_valid,
  input  logic          stream_ready,
  output logic [7:0]    out_byte,
  output logic          run_last
);

  chft_pkg::job_t slots [2];
  logic [1:0] count;
  logic       rd_ptr;
  logic       wr_ptr;
  logic [3:0] pos;

  chft_pkg::job_t head;
  logic [3:0] start_step;
  logic [3:0] end_step;
  logic [3:0] step;
  logic       push;
  logic       pop;
  logic       xfer;

  assign head         = slots[rd_ptr];
  assign start_step   = head.prefix ? chft_pkg::STEP_PRE0 : chft_pkg::STEP_DATA;
  assign end_step     = head.tail ? chft_pkg::STEP_LF : chft_pkg::STEP_DATA;
  assign step         = start_step + pos;
  assign stream_valid = (count != 2'd0);
  assign job_ready    = (count != 2'd2);
  assign run_last     = (step == end_step);
  assign xfer         = stream_valid && stream_ready;
  assign pop          = xfer && run_last;
  assign push         = job_valid && job_ready;

  // Byte selection for the current position
  always_comb begin
    case (step)
      chft_pkg::STEP_PRE0: out_byte = chft_pkg::PREFIX_A;
      chft_pkg::STEP_PRE1: out_byte = chft_pkg::PREFIX_A;
      chft_pkg::STEP_PRE2: out_byte = chft_pkg::PREFIX_B;
      chft_pkg::STEP_PRE3: out_byte = chft_pkg::PREFIX_B;
      chft_pkg::STEP_DATA: out_byte = head.data;
      chft_pkg::STEP_HEX3: out_byte = chft_pkg::hex_char(head.crc[15:12]);
      chft_pkg::STEP_HEX2: out_byte = chft_pkg::hex_char(head.crc[11:8]);
      chft_pkg::STEP_HEX1: out_byte = chft_pkg::hex_char(head.crc[7:4]);
      chft_pkg::STEP_HEX0: out_byte = chft_pkg::hex_char(head.crc[3:0]);
      chft_pkg::STEP_CR:   out_byte = chft_pkg::CHAR_CR;
      chft_pkg::STEP_LF:   out_byte = chft_pkg::CHAR_LF;
      default:             out_byte = chft_pkg::CHAR_LF;
    endcase
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= job;
    end
  end

  // Queue pointers and position within the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      pos    <= 4'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
        pos    <= 4'd0;
      end else if (xfer) begin
        pos <= pos + 4'd1;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/crc_hex_frame_transmitter.sv @@
`timescale 1ns / 1ps
// CRC-16/XMODEM framer: prefix 05 05 03 03, payload, ASCII hex CRC, CR LF.
// An accepted item is registered in the job queue; its first output byte is offered once it reaches the queue head.
// Each item yields 1 to 11 output bytes (1 for a mid-frame byte); inputs are
// taken every cycle while the two-entry job queue has room, which the output port frees.
// Reset clears the CRC, the frame flag and the queue. Depends on chft_pkg, chft_seq.
module crc_hex_frame_transmitter (
  input  logic       clk,
  input  logic       rst,
  input  logic       payload_valid,
  output logic       payload_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_payload,
  output logic       stream_valid,
  input  logic       stream_ready,
  output logic [7:0] out_byte,
  output logic       run_last
);

  logic [15:0]    crc_accum;
  logic           inside_frame;
  logic [15:0]    crc_next;
  logic           accept;
  chft_pkg::job_t job;

  assign accept   = payload_valid && payload_ready;
  assign crc_next = chft_pkg::crc_update(crc_accum, data_byte);

  // Job handed to the sequencer
  always_comb begin
    job.data   = data_byte;
    job.crc    = crc_next;
    job.prefix = ~inside_frame;
    job.tail   = end_of_payload;
  end

  // Running CRC and frame flag
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum    <= 16'd0;
      inside_frame <= 1'b0;
    end else if (accept) begin
      if (end_of_payload) begin
        crc_accum    <= 16'd0;
        inside_frame <= 1'b0;
      end else begin
        crc_accum    <= crc_next;
        inside_frame <= 1'b1;
      end
    end
  end

  chft_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (payload_valid),
    .job_ready    (payload_ready),
    .job          (job),
    .stream_valid (stream_valid),
    .stream_ready (stream_ready),
    .out_byte     (out_byte),
    .run_last     (run_last)
  );

endmodule
